/* design/obb_overlap_test_2d_macros.svh */
// Assertion macros shared by the overlap test checker.
`ifndef OBB_OVERLAP_TEST_2D_MACROS_SVH
`define OBB_OVERLAP_TEST_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBB_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("overlap test check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OBB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("overlap test check failed");

`endif

/* design/obbot_pkg.sv */
// Types, constants and saturating helpers for the 2D oriented-box overlap test.
package obbot_pkg;

	localparam int unsigned FIELD_W    = 32;
	localparam int unsigned ACC_W      = 64;
	localparam int unsigned WIDE_W     = 66;
	localparam int unsigned NUM_EDGE   = 4;
	localparam int unsigned NUM_PAIR   = 10;
	localparam int unsigned NUM_STAGES = 7;

	// Each unordered edge pair (i, j) with i <= j gets one dot product.
	localparam int unsigned PAIR_I [NUM_PAIR] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
	localparam int unsigned PAIR_J [NUM_PAIR] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

	// Pair slot of the dot product between edge i and edge j.
	localparam int unsigned PIDX [NUM_EDGE][NUM_EDGE] = '{
		'{0, 1, 2, 3},
		'{1, 4, 5, 6},
		'{2, 5, 7, 8},
		'{3, 6, 8, 9}
	};

	typedef logic signed [ACC_W-1:0]  dot_t;
	typedef logic        [ACC_W-1:0]  mag_t;
	typedef logic        [ACC_W:0]    half_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// Clamp a wide signed sum to the signed 64-bit range.
	function automatic dot_t sat_dot(input wide_t x);
		dot_t r;
		if (x[WIDE_W-1:ACC_W-1] == '0 || x[WIDE_W-1:ACC_W-1] == '1) begin
			r = x[ACC_W-1:0];
		end else if (x[WIDE_W-1]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Absolute value; the most negative value maps to 2^63 as unsigned.
	function automatic mag_t mag_of(input dot_t s);
		mag_t r;
		if (s[ACC_W-1]) begin
			r = mag_t'(-s);
		end else begin
			r = mag_t'(s);
		end
		return r;
	endfunction

	// Doubling that saturates at the all-ones value.
	function automatic mag_t dbl_sat(input mag_t m);
		mag_t r;
		if (m[ACC_W-1]) begin
			r = '1;
		end else begin
			r = {m[ACC_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Clamp a wide unsigned sum to the unsigned 64-bit range.
	function automatic mag_t sat_ext(input logic [WIDE_W-1:0] x);
		mag_t r;
		if (|x[WIDE_W-1:ACC_W]) begin
			r = '1;
		end else begin
			r = x[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

/* design/obb_overlap_test_2d.sv */
// Separating-axis overlap test for two 2D oriented boxes, seven-stage pipeline.
// The multiplier stage holds 28 products side by side; each request passes the stages in order.
// Throughput is one box pair per cycle unless the output stalls.
// A stall on the output holds the full stages and lets upstream bubbles close up.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module obb_overlap_test_2d
	import obbot_pkg::*;
#(
	// Coordinate bits used from each field, sign-extended; range 16 to 32.
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FIELD_W-1:0]  a_xedge_x,
	input  logic [FIELD_W-1:0]  a_xedge_y,
	input  logic [FIELD_W-1:0]  a_yedge_x,
	input  logic [FIELD_W-1:0]  a_yedge_y,
	input  logic [FIELD_W-1:0]  a_center_x,
	input  logic [FIELD_W-1:0]  a_center_y,
	input  logic [FIELD_W-1:0]  b_xedge_x,
	input  logic [FIELD_W-1:0]  b_xedge_y,
	input  logic [FIELD_W-1:0]  b_yedge_x,
	input  logic [FIELD_W-1:0]  b_yedge_y,
	input  logic [FIELD_W-1:0]  b_center_x,
	input  logic [FIELD_W-1:0]  b_center_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                overlapping
);

	localparam int unsigned CW  = COORD_WIDTH;
	localparam int unsigned DW  = CW + 1;
	localparam int unsigned EPW = 2 * CW;
	localparam int unsigned CPW = DW + CW;

	// Stage control: a stage loads when it is empty or the next one moves.
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES:1]   vld_in;
	logic [NUM_STAGES+1:1] go;

	assign go[NUM_STAGES+1] = !out_stall;
	assign vld_in = {vld_q[NUM_STAGES-1:1], in_valid};

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_ctl
		assign go[k] = !vld_q[k] || go[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (go[k]) begin
				vld_q[k] <= vld_in[k];
			end
		end
	end

	assign in_stall  = !go[1];
	assign out_valid = vld_q[NUM_STAGES];

	// Input selection: the low CW bits of each edge and center field, read as signed.
	logic signed [CW-1:0] ex_in [NUM_EDGE];
	logic signed [CW-1:0] ey_in [NUM_EDGE];
	logic signed [CW-1:0] ac_x, ac_y, bc_x, bc_y;

	always_comb begin
		ex_in[0] = a_xedge_x[CW-1:0];
		ey_in[0] = a_xedge_y[CW-1:0];
		ex_in[1] = a_yedge_x[CW-1:0];
		ey_in[1] = a_yedge_y[CW-1:0];
		ex_in[2] = b_xedge_x[CW-1:0];
		ey_in[2] = b_xedge_y[CW-1:0];
		ex_in[3] = b_yedge_x[CW-1:0];
		ey_in[3] = b_yedge_y[CW-1:0];
		ac_x     = a_center_x[CW-1:0];
		ac_y     = a_center_y[CW-1:0];
		bc_x     = b_center_x[CW-1:0];
		bc_y     = b_center_y[CW-1:0];
	end

	// Stage 1: register the edges and the center difference.
	logic signed [CW-1:0] ex_s1 [NUM_EDGE];
	logic signed [CW-1:0] ey_s1 [NUM_EDGE];
	logic signed [DW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			ex_s1 <= ex_in;
			ey_s1 <= ey_in;
			dx_s1 <= DW'(bc_x) - DW'(ac_x);
			dy_s1 <= DW'(bc_y) - DW'(ac_y);
		end
	end

	// Stage 2: component products for every edge pair and every axis.
	logic signed [EPW-1:0] pex_s2 [NUM_PAIR];
	logic signed [EPW-1:0] pey_s2 [NUM_PAIR];
	logic signed [CPW-1:0] pcx_s2 [NUM_EDGE];
	logic signed [CPW-1:0] pcy_s2 [NUM_EDGE];

	for (genvar p = 0; p < NUM_PAIR; p++) begin : g_emul
		always_ff @(posedge clk) begin
			if (go[2]) begin
				pex_s2[p] <= EPW'(ex_s1[PAIR_I[p]]) * EPW'(ex_s1[PAIR_J[p]]);
				pey_s2[p] <= EPW'(ey_s1[PAIR_I[p]]) * EPW'(ey_s1[PAIR_J[p]]);
			end
		end
	end

	for (genvar i = 0; i < NUM_EDGE; i++) begin : g_cmul
		always_ff @(posedge clk) begin
			if (go[2]) begin
				pcx_s2[i] <= CPW'(dx_s1) * CPW'(ex_s1[i]);
				pcy_s2[i] <= CPW'(dy_s1) * CPW'(ey_s1[i]);
			end
		end
	end

	// Stage 3: dot products, clamped to the signed 64-bit range.
	dot_t de_s3 [NUM_PAIR];
	dot_t dc_s3 [NUM_EDGE];

	for (genvar p = 0; p < NUM_PAIR; p++) begin : g_edot
		always_ff @(posedge clk) begin
			if (go[3]) begin
				de_s3[p] <= sat_dot(wide_t'(pex_s2[p]) + wide_t'(pey_s2[p]));
			end
		end
	end

	for (genvar i = 0; i < NUM_EDGE; i++) begin : g_cdot
		always_ff @(posedge clk) begin
			if (go[3]) begin
				dc_s3[i] <= sat_dot(wide_t'(pcx_s2[i]) + wide_t'(pcy_s2[i]));
			end
		end
	end

	// Stage 4: magnitudes; the center side is doubled with saturation.
	mag_t me_s4 [NUM_PAIR];
	mag_t c2_s4 [NUM_EDGE];

	for (genvar p = 0; p < NUM_PAIR; p++) begin : g_emag
		always_ff @(posedge clk) begin
			if (go[4]) begin
				me_s4[p] <= mag_of(de_s3[p]);
			end
		end
	end

	for (genvar i = 0; i < NUM_EDGE; i++) begin : g_cmag
		always_ff @(posedge clk) begin
			if (go[4]) begin
				c2_s4[i] <= dbl_sat(mag_of(dc_s3[i]));
			end
		end
	end

	// Stages 5 and 6: extent of both boxes on each axis, summed as a tree.
	half_t hs0_s5 [NUM_EDGE];
	half_t hs1_s5 [NUM_EDGE];
	mag_t  c2_s5  [NUM_EDGE];
	mag_t  ext_s6 [NUM_EDGE];
	mag_t  c2_s6  [NUM_EDGE];

	for (genvar i = 0; i < NUM_EDGE; i++) begin : g_ext
		always_ff @(posedge clk) begin
			if (go[5]) begin
				hs0_s5[i] <= {1'b0, me_s4[PIDX[i][0]]} + {1'b0, me_s4[PIDX[i][1]]};
				hs1_s5[i] <= {1'b0, me_s4[PIDX[i][2]]} + {1'b0, me_s4[PIDX[i][3]]};
				c2_s5[i]  <= c2_s4[i];
			end
		end

		always_ff @(posedge clk) begin
			if (go[6]) begin
				ext_s6[i] <= sat_ext({1'b0, hs0_s5[i]} + {1'b0, hs1_s5[i]});
				c2_s6[i]  <= c2_s5[i];
			end
		end
	end

	// Stage 7: an axis separates when the doubled center projection exceeds the extent.
	logic [NUM_EDGE-1:0] sep;
	logic                overlapping_s7;

	always_comb begin
		for (int unsigned i = 0; i < NUM_EDGE; i++) begin
			sep[i] = c2_s6[i] > ext_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (go[7]) begin
			overlapping_s7 <= ~|sep;
		end
	end

	assign overlapping = overlapping_s7;

endmodule

/* design/obbot_checker.sv */
// Port-level checker for the overlap test pipeline, bound to the top level.
`include "obb_overlap_test_2d_macros.svh"

module obbot_checker
	import obbot_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic overlapping
);

	localparam int unsigned CNT_W = $clog2(NUM_STAGES + 2);

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] pend_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Requests taken in but whose results have not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// A stalled result holds its value.
	`OBB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(overlapping))

	// The input backs up only when every stage is full behind a stalled output.
	`OBB_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// Every result belongs to an earlier request.
	`OBB_ASSERT_IMPL(a_no_extra, clk, arst_n, out_valid, pend_q != '0)

	// The pipeline never holds more requests than it has stages.
	`OBB_ASSERT_IMPL(a_depth, clk, arst_n, 1'b1, pend_q <= CNT_W'(NUM_STAGES))

endmodule

bind obb_overlap_test_2d obbot_checker u_obbot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.overlapping (overlapping)
);

/* bench/testbench.sv */
// Self-checking bench for the streaming 2D oriented-box overlap test.
`timescale 1ns / 1ps

module testbench;
	import obbot_pkg::*;

	localparam int unsigned COORD_W = 32;
	localparam int ONE = 65536;
	localparam int NUM_RANDOM = 600;
	localparam int QUIET_TAIL = 80;
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 80;
	localparam int DRAIN_CYCLES = 30;
	localparam logic signed [65:0] DOT_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [65:0] DOT_MIN = -DOT_MAX - 66'sd1;

	// One box pair as presented on the request channel.
	typedef struct packed {
		logic [FIELD_W-1:0] a_xedge_x;
		logic [FIELD_W-1:0] a_xedge_y;
		logic [FIELD_W-1:0] a_yedge_x;
		logic [FIELD_W-1:0] a_yedge_y;
		logic [FIELD_W-1:0] a_center_x;
		logic [FIELD_W-1:0] a_center_y;
		logic [FIELD_W-1:0] b_xedge_x;
		logic [FIELD_W-1:0] b_xedge_y;
		logic [FIELD_W-1:0] b_yedge_x;
		logic [FIELD_W-1:0] b_yedge_y;
		logic [FIELD_W-1:0] b_center_x;
		logic [FIELD_W-1:0] b_center_y;
	} box_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlapping;
	box_pair_t drive_req = '0;

	box_pair_t pending_pairs[$];
	logic overlap_expected[$];
	logic req_taken = 1'b0;
	int total_reqs = 0;
	int accepted_cnt = 0;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cnt = 0;
	logic hold_done = 1'b0;
	logic quiet;

	assign quiet = (accepted_cnt >= total_reqs - QUIET_TAIL);

	obb_overlap_test_2d #(.COORD_WIDTH(COORD_W)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_xedge_x  (drive_req.a_xedge_x),
		.a_xedge_y  (drive_req.a_xedge_y),
		.a_yedge_x  (drive_req.a_yedge_x),
		.a_yedge_y  (drive_req.a_yedge_y),
		.a_center_x (drive_req.a_center_x),
		.a_center_y (drive_req.a_center_y),
		.b_xedge_x  (drive_req.b_xedge_x),
		.b_xedge_y  (drive_req.b_xedge_y),
		.b_yedge_x  (drive_req.b_yedge_x),
		.b_yedge_y  (drive_req.b_yedge_y),
		.b_center_x (drive_req.b_center_x),
		.b_center_y (drive_req.b_center_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.overlapping(overlapping)
	);

	// Coordinate as used by the block: low bits sign-extended.
	function automatic logic signed [63:0] coord_of(input logic [FIELD_W-1:0] raw);
		logic signed [31:0] v;
		v = raw << (32 - COORD_W);
		v = v >>> (32 - COORD_W);
		return 64'(v);
	endfunction

	// Two-term dot product, clamped to the signed 64-bit range.
	function automatic logic signed [63:0] dot_clamped(input logic signed [65:0] px,
			input logic signed [65:0] vx, input logic signed [65:0] py,
			input logic signed [65:0] vy);
		logic signed [65:0] s;
		s = px * vx + py * vy;
		if (s > DOT_MAX) begin
			s = DOT_MAX;
		end else if (s < DOT_MIN) begin
			s = DOT_MIN;
		end
		return s[63:0];
	endfunction

	// Magnitude as unsigned; the most negative value becomes 2^63.
	function automatic logic [63:0] dot_mag(input logic signed [63:0] s);
		logic [63:0] u;
		u = s;
		return s[63] ? (~u + 64'd1) : u;
	endfunction

	// Separating-axis test on the edge axes of both boxes without normalization.
	function automatic logic predict_overlap(input box_pair_t p);
		logic signed [63:0] ex [4];
		logic signed [63:0] ey [4];
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic [65:0] extent;
		logic [63:0] ext_sat;
		logic [63:0] cmag;
		logic [63:0] c2;
		logic sep;
		ex[0] = coord_of(p.a_xedge_x);
		ey[0] = coord_of(p.a_xedge_y);
		ex[1] = coord_of(p.a_yedge_x);
		ey[1] = coord_of(p.a_yedge_y);
		ex[2] = coord_of(p.b_xedge_x);
		ey[2] = coord_of(p.b_xedge_y);
		ex[3] = coord_of(p.b_yedge_x);
		ey[3] = coord_of(p.b_yedge_y);
		dx = coord_of(p.b_center_x) - coord_of(p.a_center_x);
		dy = coord_of(p.b_center_y) - coord_of(p.a_center_y);
		sep = 1'b0;
		for (int i = 0; i < 4; i++) begin
			extent = '0;
			for (int j = 0; j < 4; j++) begin
				extent = extent + dot_mag(dot_clamped(ex[j], ex[i], ey[j], ey[i]));
			end
			// All terms are non-negative, so one clamp at the end is enough.
			ext_sat = (extent[65:64] != 2'b00) ? '1 : extent[63:0];
			cmag = dot_mag(dot_clamped(dx, ex[i], dy, ey[i]));
			c2 = cmag[63] ? '1 : {cmag[62:0], 1'b0};
			if (c2 > ext_sat) begin
				sep = 1'b1;
			end
		end
		return !sep;
	endfunction

	function automatic box_pair_t pair_of(input int axx, input int axy, input int ayx,
			input int ayy, input int acx, input int acy, input int bxx, input int bxy,
			input int byx, input int byy, input int bcx, input int bcy);
		box_pair_t p;
		p.a_xedge_x = axx;
		p.a_xedge_y = axy;
		p.a_yedge_x = ayx;
		p.a_yedge_y = ayy;
		p.a_center_x = acx;
		p.a_center_y = acy;
		p.b_xedge_x = bxx;
		p.b_xedge_y = bxy;
		p.b_yedge_x = byx;
		p.b_yedge_y = byy;
		p.b_center_x = bcx;
		p.b_center_y = bcy;
		return p;
	endfunction

	// Random signed coordinate with its magnitude reduced by a shift.
	function automatic int rand_coord(input int sh);
		int r;
		r = $urandom;
		return r >>> sh;
	endfunction

	// Plausible box pair: mostly rectangles, centers close enough to sometimes touch.
	function automatic box_pair_t rand_formed_pair();
		box_pair_t p;
		int sha;
		int shb;
		int vx;
		int vy;
		sha = $urandom_range(6, 26);
		shb = sha + $urandom_range(0, 2);
		vx = rand_coord(sha);
		vy = rand_coord(sha);
		p.a_xedge_x = vx;
		p.a_xedge_y = vy;
		if ($urandom_range(0, 3) != 0) begin
			p.a_yedge_x = (-vy) >>> $urandom_range(0, 2);
			p.a_yedge_y = vx >>> $urandom_range(0, 2);
		end else begin
			p.a_yedge_x = rand_coord(sha);
			p.a_yedge_y = rand_coord(sha);
		end
		vx = rand_coord(shb);
		vy = rand_coord(shb);
		p.b_xedge_x = vx;
		p.b_xedge_y = vy;
		if ($urandom_range(0, 3) != 0) begin
			p.b_yedge_x = vy >>> $urandom_range(0, 2);
			p.b_yedge_y = (-vx) >>> $urandom_range(0, 2);
		end else begin
			p.b_yedge_x = rand_coord(shb);
			p.b_yedge_y = rand_coord(shb);
		end
		p.a_center_x = $urandom;
		p.a_center_y = $urandom;
		p.b_center_x = int'(p.a_center_x) + rand_coord(sha - 1 + $urandom_range(0, 2));
		p.b_center_y = int'(p.a_center_y) + rand_coord(sha - 1 + $urandom_range(0, 2));
		return p;
	endfunction

	// Stimulus: directed corner cases first, then random pairs.
	initial begin
		int mx;
		int mn;
		int h;
		box_pair_t p;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		h = 46341;
		// Zero-length axes everywhere: nothing can separate.
		pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Coincident unit squares, exact touching, one step past touching, and well apart.
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0));
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE, 0));
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE + 1, 0));
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 3 * ONE));
		// Rotated box near the other, overlapping and just apart.
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, h, h, -h, h, ONE, ONE / 4));
		pending_pairs.push_back(pair_of(ONE, 0, 0, ONE, 0, 0, h, h, -h, h, ONE, ONE));
		// Point-sized box inside and outside the other.
		pending_pairs.push_back(pair_of(0, 0, 0, 0, 100, -100, ONE, 0, 0, ONE, 100, -100));
		pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE, 2 * ONE, 0));
		// Two points at different places: all axes vanish.
		pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5 * ONE, -7 * ONE));
		// Parallel edges make a degenerate box.
		pending_pairs.push_back(pair_of(ONE, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 2 * ONE));
		pending_pairs.push_back(pair_of(ONE, ONE, 2 * ONE, 2 * ONE, 0, 0, ONE, -ONE, 0, 0,
			3 * ONE, 3 * ONE));
		// Field extremes and saturated sums.
		pending_pairs.push_back(pair_of(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
		pending_pairs.push_back(pair_of(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
		pending_pairs.push_back(pair_of(mx, mx, mx, mx, mn, mn, mx, mx, mx, mx, mx, mx));
		pending_pairs.push_back(pair_of(mn, mn, mn, mn, mx, mx, mn, mn, mn, mn, mn, mn));
		pending_pairs.push_back(pair_of(mx, mn, mn, mx, mn, mx, mn, mx, mx, mn, mx, mn));
		pending_pairs.push_back(pair_of(1, 0, 0, 1, mn, 0, 1, 0, 0, 1, mx, 0));
		pending_pairs.push_back(pair_of(mx, 0, 0, mx, 0, 0, 1, 1, -1, 1, mx, mx));
		pending_pairs.push_back(pair_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		pending_pairs.push_back(pair_of(-ONE, 0, 0, -ONE, 0, 0, -ONE, 0, 0, -ONE,
			-ONE - 1, 0));
		// Random part: mostly plausible boxes, the rest raw noise.
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				p = pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				p = rand_formed_pair();
			end
			pending_pairs.push_back(p);
		end
		total_reqs = pending_pairs.size();
	end

	// Clock and a single reset at the start.
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Sender: offers the next request, with random idle bursts between requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				if (!quiet && hold_cnt == 0 && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
					in_valid <= 1'b0;
				end else begin
					drive_req <= pending_pairs[0];
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off to back up the pipeline.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_cnt = HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap = recv_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(1, 14) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: record accepted requests and check each accepted result in order.
	always @(posedge clk) begin
		logic want;
		if (arst_n) begin
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				overlap_expected.push_back(predict_overlap(drive_req));
				void'(pending_pairs.pop_front());
				accepted_cnt <= accepted_cnt + 1;
			end
			if (out_valid && !out_stall) begin
				if (overlap_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0b",
						$time, overlapping);
					mismatches <= mismatches + 1;
				end else begin
					want = overlap_expected.pop_front();
					if (overlapping !== want) begin
						$display("%0t: overlapping mismatch, expected %0b, actual %0b",
							$time, want, overlapping);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	// End of run: drain, wait a further drain period, then report.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		while (overlap_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && overlap_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/obbot_pkg.sv
design/obb_overlap_test_2d.sv
design/obbot_checker.sv
bench/testbench.sv
